// File: sv/rsfe_pkg.sv
`timescale 1ns / 1ps
package rsfe_pkg;

   localparam int RSFE_REG_COUNT = 16;

   localparam logic [7:0]  FC_READ  = 8'h03;
   localparam logic [7:0]  FC_WRITE = 8'h06;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   localparam logic [1:0] KIND_LINK  = 2'd0;
   localparam logic [1:0] KIND_LWRITE = 2'd1;
   localparam logic [1:0] KIND_LREAD = 2'd2;

   typedef enum logic [2:0] {
      SEL_HDR     = 3'd0,
      SEL_DATA_HI = 3'd1,
      SEL_DATA_LO = 3'd2,
      SEL_CRC_LO  = 3'd3,
      SEL_CRC_HI  = 3'd4,
      SEL_LOCAL   = 3'd5
   } rsfe_sel_type;

   typedef struct packed {
      logic         take_byte;
      logic         local_wr;
      logic         reply_start;
      logic         mem_rd;
      logic         rd_local;
      logic         emit;
      rsfe_sel_type sel;
      logic         hdr_inc;
      logic         ptr_step;
   } rsfe_cmd_type;

   typedef struct packed {
      logic frame_go;
      logic is_write;
      logic out_free;
      logic hdr_last;
      logic rem_zero;
      logic rem_one;
   } rsfe_sts_type;

   // CRC-16/MODBUS, one byte, bit by bit
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// File: sv/register_slave_frame_engine.sv
`timescale 1ns / 1ps
// Register slave frame engine: takes link bytes, local register writes and local register
// reads one word at a time. A link byte or a local write goes straight back to idle; a local
// read registers the store word and then waits for a free output word before it is put on
// the output. When the last byte of a good frame arrives the engine stays busy until the
// whole reply has been handed out: it emits each header byte in turn, for each register of a
// read reply it reads the single read port of the register store and then emits the high
// and the low byte, and it ends with the two CRC bytes; any stall on rsp_ready holds it.
// The store is cleared at reset by per-entry valid bits, so there is no clearing pass;
// csr_wdata sets the device address (reset 0xFF).
module register_slave_frame_engine #(
   parameter int REG_COUNT = rsfe_pkg::RSFE_REG_COUNT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_rx_byte,
   input  logic [15:0] req_local_addr,
   input  logic [15:0] req_local_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_is_local_answer,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_tx_last,
   output logic [15:0] rsp_read_value
);
   import rsfe_pkg::*;

   rsfe_cmd_type cmd;
   rsfe_sts_type sts;

   rsfe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_kind  (req_kind),
      .sts       (sts),
      .cmd       (cmd)
   );

   rsfe_dp #(
      .REG_COUNT (REG_COUNT)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .csr_we              (csr_we),
      .csr_wdata           (csr_wdata),
      .req_rx_byte         (req_rx_byte),
      .req_local_addr      (req_local_addr),
      .req_local_value     (req_local_value),
      .rsp_ready           (rsp_ready),
      .rsp_valid           (rsp_valid),
      .rsp_is_local_answer (rsp_is_local_answer),
      .rsp_tx_byte         (rsp_tx_byte),
      .rsp_tx_last         (rsp_tx_last),
      .rsp_read_value      (rsp_read_value)
   );

endmodule

// File: sv/rsfe_dp.sv
`timescale 1ns / 1ps
module rsfe_dp #(
   parameter int REG_COUNT = rsfe_pkg::RSFE_REG_COUNT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rsfe_pkg::rsfe_cmd_type cmd,
   output rsfe_pkg::rsfe_sts_type sts,
   input  logic                  csr_we,
   input  logic [7:0]            csr_wdata,
   input  logic [7:0]            req_rx_byte,
   input  logic [15:0]           req_local_addr,
   input  logic [15:0]           req_local_value,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic                  rsp_is_local_answer,
   output logic [7:0]            rsp_tx_byte,
   output logic                  rsp_tx_last,
   output logic [15:0]           rsp_read_value
);
   import rsfe_pkg::*;

   localparam int AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
   localparam int CW = $clog2(REG_COUNT + 1);
   localparam logic [16:0] RC17 = 17'(REG_COUNT);
   localparam logic [15:0] RC16 = 16'(REG_COUNT);
   localparam logic [2:0]  HDR_LAST_WR = 3'd5;
   localparam logic [2:0]  HDR_LAST_RD = 3'd2;

   logic [7:0]  dev_ff, dev_in;
   logic [2:0]  pos_ff, pos_in;
   logic [15:0] rx_crc_ff, rx_crc_in;
   logic        is_wr_ff, is_wr_in;
   logic [15:0] faddr_ff, faddr_in;
   logic [15:0] fval_ff, fval_in;
   logic [15:0] crc_base, crc_next;
   logic        frame_hit, addr_ok, span_ok;

   logic [2:0]    hdr_idx_ff, hdr_idx_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic [CW-1:0] rem_ff, rem_in;
   logic [15:0]   tx_crc_ff, tx_crc_in;

   logic [15:0]          mem [REG_COUNT];
   logic [REG_COUNT-1:0] vld_ff;
   logic [15:0]          rd_data_ff;
   logic                 rd_ok_ff;
   logic                 local_ok, wr_en, rd_hit;
   logic [AW-1:0]        wr_idx, rd_idx;
   logic [15:0]          wr_data, rd_val;

   logic        out_valid_ff, out_valid_in;
   logic        out_local_ff, out_local_in;
   logic [7:0]  out_byte_ff, out_byte_in;
   logic        out_last_ff, out_last_in;
   logic [15:0] out_val_ff, out_val_in;
   logic [7:0]  hdr_byte, emit_byte;

   // frame receiver
   assign crc_base  = (pos_ff == 3'd0) ? CRC_INIT : rx_crc_ff;
   assign crc_next  = crc_byte(crc_base, req_rx_byte);
   assign frame_hit = (pos_ff == 3'd7) && (req_rx_byte == rx_crc_ff[15:8]);
   assign addr_ok   = faddr_ff < RC16;
   assign span_ok   = ({1'b0, faddr_ff} + {1'b0, fval_ff}) <= RC17;

   always_comb begin
      dev_in    = csr_we ? csr_wdata : dev_ff;
      pos_in    = pos_ff;
      rx_crc_in = rx_crc_ff;
      is_wr_in  = is_wr_ff;
      faddr_in  = faddr_ff;
      fval_in   = fval_ff;
      if (cmd.take_byte) begin
         unique case (pos_ff)
            3'd0: pos_in = (req_rx_byte == dev_ff) ? 3'd1 : 3'd0;
            3'd1: begin
               if (req_rx_byte == FC_READ || req_rx_byte == FC_WRITE) begin
                  is_wr_in = (req_rx_byte == FC_WRITE);
                  pos_in   = 3'd2;
               end else begin
                  pos_in = 3'd0;
               end
            end
            3'd2: begin
               faddr_in = {req_rx_byte, 8'h00};
               pos_in   = 3'd3;
            end
            3'd3: begin
               faddr_in = {faddr_ff[15:8], req_rx_byte};
               pos_in   = 3'd4;
            end
            3'd4: begin
               fval_in = {req_rx_byte, 8'h00};
               pos_in  = 3'd5;
            end
            3'd5: begin
               fval_in = {fval_ff[15:8], req_rx_byte};
               pos_in  = 3'd6;
            end
            3'd6: pos_in = (req_rx_byte == rx_crc_ff[7:0]) ? 3'd7 : 3'd0;
            default: pos_in = 3'd0;
         endcase
         if (pos_in != 3'd7) begin
            rx_crc_in = crc_next;
         end
      end
   end

   // register store
   assign local_ok = req_local_addr < RC16;
   assign wr_en    = (cmd.local_wr && local_ok) || (cmd.reply_start && is_wr_ff);
   assign wr_idx   = cmd.local_wr ? req_local_addr[AW-1:0] : faddr_ff[AW-1:0];
   assign wr_data  = cmd.local_wr ? req_local_value : fval_ff;
   assign rd_idx   = cmd.rd_local ? req_local_addr[AW-1:0] : ptr_ff;
   assign rd_hit   = (!cmd.rd_local || local_ok) && vld_ff[rd_idx];
   assign rd_val   = rd_ok_ff ? rd_data_ff : 16'h0000;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      if (cmd.mem_rd) begin
         rd_data_ff <= mem[rd_idx];
         rd_ok_ff   <= rd_hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_idx] <= 1'b1;
      end
   end

   // reply sequencing
   always_comb begin
      unique case (hdr_idx_ff)
         3'd0: hdr_byte = dev_ff;
         3'd1: hdr_byte = is_wr_ff ? FC_WRITE : FC_READ;
         3'd2: hdr_byte = is_wr_ff ? faddr_ff[15:8] : {fval_ff[6:0], 1'b0};
         3'd3: hdr_byte = faddr_ff[7:0];
         3'd4: hdr_byte = fval_ff[15:8];
         default: hdr_byte = fval_ff[7:0];
      endcase
   end

   always_comb begin
      case (cmd.sel)
         SEL_HDR:     emit_byte = hdr_byte;
         SEL_DATA_HI: emit_byte = rd_val[15:8];
         SEL_DATA_LO: emit_byte = rd_val[7:0];
         SEL_CRC_LO:  emit_byte = tx_crc_ff[7:0];
         SEL_CRC_HI:  emit_byte = tx_crc_ff[15:8];
         default:     emit_byte = 8'h00;
      endcase
   end

   always_comb begin
      hdr_idx_in = hdr_idx_ff;
      ptr_in     = ptr_ff;
      rem_in     = rem_ff;
      tx_crc_in  = tx_crc_ff;
      if (cmd.reply_start) begin
         hdr_idx_in = 3'd0;
         ptr_in     = faddr_ff[AW-1:0];
         rem_in     = fval_ff[CW-1:0];
         tx_crc_in  = CRC_INIT;
      end else begin
         if (cmd.hdr_inc) begin
            hdr_idx_in = hdr_idx_ff + 3'd1;
         end
         if (cmd.ptr_step) begin
            ptr_in = ptr_ff + AW'(1);
            rem_in = rem_ff - CW'(1);
         end
         if (cmd.emit && (cmd.sel == SEL_HDR || cmd.sel == SEL_DATA_HI ||
                          cmd.sel == SEL_DATA_LO)) begin
            tx_crc_in = crc_byte(tx_crc_ff, emit_byte);
         end
      end
   end

   // output word register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_local_in = out_local_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      out_val_in   = out_val_ff;
      if (cmd.emit) begin
         out_valid_in = 1'b1;
         out_local_in = (cmd.sel == SEL_LOCAL);
         out_byte_in  = emit_byte;
         out_last_in  = (cmd.sel == SEL_CRC_HI);
         out_val_in   = (cmd.sel == SEL_LOCAL) ? rd_val : 16'h0000;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_ff       <= 8'hFF;
         pos_ff       <= 3'd0;
         out_valid_ff <= 1'b0;
      end else begin
         dev_ff       <= dev_in;
         pos_ff       <= pos_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rx_crc_ff    <= rx_crc_in;
      is_wr_ff     <= is_wr_in;
      faddr_ff     <= faddr_in;
      fval_ff      <= fval_in;
      hdr_idx_ff   <= hdr_idx_in;
      ptr_ff       <= ptr_in;
      rem_ff       <= rem_in;
      tx_crc_ff    <= tx_crc_in;
      out_local_ff <= out_local_in;
      out_byte_ff  <= out_byte_in;
      out_last_ff  <= out_last_in;
      out_val_ff   <= out_val_in;
   end

   always_comb begin
      sts.frame_go = frame_hit && addr_ok && (is_wr_ff || span_ok);
      sts.is_write = is_wr_ff;
      sts.out_free = !out_valid_ff || rsp_ready;
      sts.hdr_last = (hdr_idx_ff == (is_wr_ff ? HDR_LAST_WR : HDR_LAST_RD));
      sts.rem_zero = (rem_ff == '0);
      sts.rem_one  = (rem_ff == CW'(1));
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_is_local_answer = out_local_ff;
   assign rsp_tx_byte         = out_byte_ff;
   assign rsp_tx_last         = out_last_ff;
   assign rsp_read_value      = out_val_ff;

endmodule

// File: sv/rsfe_ctrl.sv
`timescale 1ns / 1ps
module rsfe_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_kind,
   input  rsfe_pkg::rsfe_sts_type sts,
   output rsfe_pkg::rsfe_cmd_type cmd
);
   import rsfe_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_LREAD = 8'b0000_0010,
      ST_HDR   = 8'b0000_0100,
      ST_RREQ  = 8'b0000_1000,
      ST_RHI   = 8'b0001_0000,
      ST_RLO   = 8'b0010_0000,
      ST_CRCLO = 8'b0100_0000,
      ST_CRCHI = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = (state_ff == ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_kind)
                  KIND_LINK: begin
                     cmd.take_byte = 1'b1;
                     if (sts.frame_go) begin
                        cmd.reply_start = 1'b1;
                        state_in        = ST_HDR;
                     end
                  end
                  KIND_LWRITE: cmd.local_wr = 1'b1;
                  KIND_LREAD: begin
                     cmd.mem_rd   = 1'b1;
                     cmd.rd_local = 1'b1;
                     state_in     = ST_LREAD;
                  end
                  default: ;
               endcase
            end
         end
         ST_LREAD: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = SEL_LOCAL;
               state_in = ST_IDLE;
            end
         end
         ST_HDR: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = SEL_HDR;
               if (sts.hdr_last) begin
                  state_in = (sts.is_write || sts.rem_zero) ? ST_CRCLO : ST_RREQ;
               end else begin
                  cmd.hdr_inc = 1'b1;
               end
            end
         end
         ST_RREQ: begin
            cmd.mem_rd = 1'b1;
            state_in   = ST_RHI;
         end
         ST_RHI: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = SEL_DATA_HI;
               state_in = ST_RLO;
            end
         end
         ST_RLO: begin
            if (sts.out_free) begin
               cmd.emit     = 1'b1;
               cmd.sel      = SEL_DATA_LO;
               cmd.ptr_step = 1'b1;
               state_in     = sts.rem_one ? ST_CRCLO : ST_RREQ;
            end
         end
         ST_CRCLO: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = SEL_CRC_LO;
               state_in = ST_CRCHI;
            end
         end
         ST_CRCHI: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = SEL_CRC_HI;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: sv/rsfe_checker.sv
`timescale 1ns / 1ps
module rsfe_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_is_local_answer,
   input logic [7:0]  rsp_tx_byte,
   input logic        rsp_tx_last,
   input logic [15:0] rsp_read_value
);

   a_reset_clears_out: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("output word valid after reset");

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tx_byte) &&
                                  $stable(rsp_read_value) && $stable(rsp_tx_last))
      else $error("stalled output word changed");

   a_local_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_local_answer |-> rsp_tx_byte == 8'h00 && !rsp_tx_last)
      else $error("local answer carries link fields");

   a_link_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_local_answer |-> rsp_read_value == 16'h0000)
      else $error("link byte carries a read value");

   a_busy_in_reply: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_local_answer && !rsp_tx_last |-> !req_ready)
      else $error("request taken in the middle of a reply");

endmodule

bind register_slave_frame_engine rsfe_checker u_rsfe_checker (.*);

// File: bench/frame_reply_checker.sv
`timescale 1ns / 1ps
package frame_crc_pkg;

   // CRC-16/MODBUS over one byte, data bit merged into the LSB each step
   function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] r;
      r = crc;
      for (int i = 0; i < 8; i++) begin
         if (r[0] ^ b[i]) r = (r >> 1) ^ rsfe_pkg::CRC_POLY;
         else r = r >> 1;
      end
      return r;
   endfunction

endpackage

module frame_reply_checker #(
   parameter int DEPTH = rsfe_pkg::RSFE_REG_COUNT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_rx_byte,
   input  logic [15:0] req_local_addr,
   input  logic [15:0] req_local_value,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_is_local_answer,
   input  logic [7:0]  rsp_tx_byte,
   input  logic        rsp_tx_last,
   input  logic [15:0] rsp_read_value,
   output int          fail_count,
   output int          words_due
);
   import rsfe_pkg::*;
   import frame_crc_pkg::*;

   typedef struct packed {
      logic        is_local;
      logic [7:0]  tx_byte;
      logic        tx_last;
      logic [15:0] read_value;
   } reply_word_type;

   reply_word_type reply_due[$];

   logic [7:0]  dev_addr;
   logic [2:0]  frame_pos;
   logic [15:0] rx_crc;
   logic        frame_is_write;
   logic [15:0] frame_addr;
   logic [15:0] frame_value;
   logic [15:0] regs [DEPTH];
   logic [7:0]  msg [5 + 2 * DEPTH + 2];

   initial begin
      fail_count = 0;
      words_due = 0;
   end

   // append CRC to msg[0..len-1] and queue the whole run
   task automatic queue_reply(input int len);
      logic [15:0] crc;
      reply_word_type w;
      crc = CRC_INIT;
      for (int i = 0; i < len; i++) crc = crc16_step(crc, msg[i]);
      msg[len] = crc[7:0];
      msg[len + 1] = crc[15:8];
      for (int i = 0; i < len + 2; i++) begin
         w.is_local = 1'b0;
         w.tx_byte = msg[i];
         w.tx_last = (i == len + 1);
         w.read_value = 16'h0000;
         reply_due.push_back(w);
      end
   endtask

   task automatic compare_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      reply_word_type want;
      int span;
      logic [7:0] b;
      if (reset) begin
         reply_due.delete();
         dev_addr = 8'hFF;
         frame_pos = 3'd0;
         rx_crc = CRC_INIT;
         frame_is_write = 1'b0;
         frame_addr = 16'h0000;
         frame_value = 16'h0000;
         for (int i = 0; i < DEPTH; i++) regs[i] = 16'h0000;
      end else begin
         if (csr_we) dev_addr = csr_wdata;
         if (rsp_valid && rsp_ready) begin
            if (reply_due.size() == 0) begin
               $error("unexpected word: tx_byte %0h read_value %0h",
                      rsp_tx_byte, rsp_read_value);
               fail_count++;
            end else begin
               want = reply_due.pop_front();
               compare_field("is_local_answer", want.is_local, rsp_is_local_answer);
               compare_field("tx_byte", want.tx_byte, rsp_tx_byte);
               compare_field("tx_last", want.tx_last, rsp_tx_last);
               compare_field("read_value", want.read_value, rsp_read_value);
            end
         end
         if (req_valid && req_ready) begin
            case (req_kind)
               KIND_LINK: begin
                  b = req_rx_byte;
                  case (frame_pos)
                     3'd0: begin
                        rx_crc = CRC_INIT;
                        frame_pos = (b == dev_addr) ? 3'd1 : 3'd0;
                     end
                     3'd1: begin
                        if (b == FC_READ || b == FC_WRITE) begin
                           frame_is_write = (b == FC_WRITE);
                           frame_pos = 3'd2;
                        end else begin
                           frame_pos = 3'd0;
                        end
                     end
                     3'd2: begin
                        frame_addr = {b, 8'h00};
                        frame_pos = 3'd3;
                     end
                     3'd3: begin
                        frame_addr[7:0] = b;
                        frame_pos = 3'd4;
                     end
                     3'd4: begin
                        frame_value = {b, 8'h00};
                        frame_pos = 3'd5;
                     end
                     3'd5: begin
                        frame_value[7:0] = b;
                        frame_pos = 3'd6;
                     end
                     3'd6: frame_pos = (b == rx_crc[7:0]) ? 3'd7 : 3'd0;
                     default: begin
                        frame_pos = 3'd0;
                        span = frame_addr + frame_value;
                        if (b == rx_crc[15:8] && frame_addr < DEPTH) begin
                           msg[0] = dev_addr;
                           if (frame_is_write) begin
                              regs[frame_addr] = frame_value;
                              msg[1] = FC_WRITE;
                              msg[2] = frame_addr[15:8];
                              msg[3] = frame_addr[7:0];
                              msg[4] = frame_value[15:8];
                              msg[5] = frame_value[7:0];
                              queue_reply(6);
                           end else if (span <= DEPTH) begin
                              msg[1] = FC_READ;
                              msg[2] = {frame_value[6:0], 1'b0};
                              for (int i = 0; i < frame_value; i++) begin
                                 msg[3 + 2 * i] = regs[frame_addr + i][15:8];
                                 msg[4 + 2 * i] = regs[frame_addr + i][7:0];
                              end
                              queue_reply(3 + 2 * frame_value);
                           end
                        end
                     end
                  endcase
                  if (frame_pos <= 3'd6) rx_crc = crc16_step(rx_crc, b);
               end
               KIND_LWRITE: begin
                  if (req_local_addr < DEPTH) regs[req_local_addr] = req_local_value;
               end
               KIND_LREAD: begin
                  want.is_local = 1'b1;
                  want.tx_byte = 8'h00;
                  want.tx_last = 1'b0;
                  want.read_value = (req_local_addr < DEPTH) ? regs[req_local_addr] : 16'h0000;
                  reply_due.push_back(want);
               end
               default: ;
            endcase
         end
      end
      words_due = reply_due.size();
   end

endmodule

// File: bench/register_slave_frame_engine_tb.sv
`timescale 1ns / 1ps
module register_slave_frame_engine_tb;
   import rsfe_pkg::*;
   import frame_crc_pkg::*;

   localparam int DEPTH = RSFE_REG_COUNT;
   localparam logic [1:0] KIND_SPARE = 2'd3;
   localparam int SETTLE = 100;
   localparam int STALL_LIMIT = 3000;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [7:0]  csr_wdata;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_kind;
   logic [7:0]  req_rx_byte;
   logic [15:0] req_local_addr;
   logic [15:0] req_local_value;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_is_local_answer;
   logic [7:0]  rsp_tx_byte;
   logic        rsp_tx_last;
   logic [15:0] rsp_read_value;

   int          fail_count;
   int          words_due;
   int          idle_pct = 31;
   int          sent_words;
   logic [7:0]  cur_dev;

   register_slave_frame_engine uut (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_kind(req_kind),
      .req_rx_byte(req_rx_byte),
      .req_local_addr(req_local_addr),
      .req_local_value(req_local_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_is_local_answer(rsp_is_local_answer),
      .rsp_tx_byte(rsp_tx_byte),
      .rsp_tx_last(rsp_tx_last),
      .rsp_read_value(rsp_read_value)
   );

   frame_reply_checker #(.DEPTH(DEPTH)) replies (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_kind(req_kind),
      .req_rx_byte(req_rx_byte),
      .req_local_addr(req_local_addr),
      .req_local_value(req_local_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_is_local_answer(rsp_is_local_answer),
      .rsp_tx_byte(rsp_tx_byte),
      .rsp_tx_last(rsp_tx_last),
      .rsp_read_value(rsp_read_value),
      .fail_count(fail_count),
      .words_due(words_due)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready = ($urandom_range(99) >= idle_pct);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("FAILURE");
      $finish;
   end

   // called at a falling edge; returns at the falling edge after the word is taken
   task automatic push_word(input logic [1:0] kind, input logic [7:0] rx,
                            input logic [15:0] la, input logic [15:0] lv);
      while ($urandom_range(99) < idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_kind = kind;
      req_rx_byte = rx;
      req_local_addr = la;
      req_local_value = lv;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      if (kind != KIND_SPARE) sent_words++;
   endtask

   task automatic send_frame(input logic [7:0] fc, input logic [15:0] addr,
                             input logic [15:0] value, input bit spoil);
      logic [7:0]  bytes [8];
      logic [15:0] crc;
      logic [7:0]  flip;
      int          at;
      bytes[0] = cur_dev;
      bytes[1] = fc;
      bytes[2] = addr[15:8];
      bytes[3] = addr[7:0];
      bytes[4] = value[15:8];
      bytes[5] = value[7:0];
      crc = CRC_INIT;
      for (int i = 0; i < 6; i++) crc = crc16_step(crc, bytes[i]);
      bytes[6] = crc[7:0];
      bytes[7] = crc[15:8];
      if (spoil) begin
         flip = $urandom_range(255, 1);
         at = $urandom_range(7);
         bytes[at] = bytes[at] ^ flip;
      end
      for (int i = 0; i < 8; i++) push_word(KIND_LINK, bytes[i], $urandom, $urandom);
   endtask

   // device address change only once the engine has drained
   task automatic retune(input logic [7:0] value);
      req_valid = 1'b0;
      while (words_due != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
      csr_we = 1'b1;
      csr_wdata = value;
      cur_dev = value;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic random_phase(input int words);
      int          start;
      int          r;
      int          room;
      logic [15:0] a;
      logic [15:0] v;
      start = sent_words;
      while (sent_words - start < words) begin
         r = $urandom_range(99);
         if (r < 28) begin
            a = $urandom_range(DEPTH - 1);
            room = DEPTH - a;
            if ($urandom_range(7) == 0) begin
               a = 16'h0000;
               v = DEPTH;
            end else begin
               v = $urandom_range(room < 3 ? room : 3);
            end
            send_frame(FC_READ, a, v, 1'b0);
         end else if (r < 50) begin
            send_frame(FC_WRITE, $urandom_range(DEPTH - 1), $urandom, 1'b0);
         end else if (r < 56) begin
            if ($urandom_range(1)) begin
               a = $urandom_range(65535, DEPTH);
               v = $urandom;
            end else begin
               a = $urandom_range(DEPTH - 1);
               v = $urandom_range(65535, DEPTH - a + 1);
            end
            send_frame(FC_READ, a, v, 1'b0);
         end else if (r < 60) begin
            send_frame(FC_WRITE, $urandom_range(65535, DEPTH), $urandom, 1'b0);
         end else if (r < 68) begin
            send_frame($urandom_range(1) ? FC_WRITE : FC_READ, $urandom_range(DEPTH - 1),
                       $urandom_range(3), 1'b1);
         end else if (r < 72) begin
            send_frame($urandom_range(255), $urandom, $urandom, 1'b0);
         end else if (r < 80) begin
            a = ($urandom_range(3) == 0) ? $urandom : $urandom_range(DEPTH - 1);
            push_word(KIND_LWRITE, $urandom, a, $urandom);
         end else if (r < 92) begin
            a = ($urandom_range(3) == 0) ? $urandom : $urandom_range(DEPTH - 1);
            push_word(KIND_LREAD, $urandom, a, $urandom);
         end else if (r < 97) begin
            push_word(KIND_LINK, $urandom, $urandom, $urandom);
         end else begin
            push_word(KIND_SPARE, $urandom, $urandom, $urandom);
         end
      end
   endtask

   initial begin : stimulus
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = 8'h00;
      req_valid = 1'b0;
      req_kind = KIND_LINK;
      req_rx_byte = 8'h00;
      req_local_addr = 16'h0000;
      req_local_value = 16'h0000;
      sent_words = 0;
      cur_dev = 8'hFF;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      push_word(KIND_LWRITE, 8'h00, 16'h0000, 16'hFFFF);
      push_word(KIND_LWRITE, 8'hFF, DEPTH - 1, 16'hA5C3);
      push_word(KIND_LWRITE, 8'h00, 16'hFFFF, 16'h1234);
      push_word(KIND_LREAD, 8'h00, DEPTH - 1, 16'h0000);
      push_word(KIND_LREAD, 8'h00, 16'hFFFF, 16'hFFFF);
      push_word(KIND_SPARE, 8'hFF, 16'h0000, 16'h0000);
      // foreign address, then a full write, a local read of the written register and a zero-count read
      push_word(KIND_LINK, 8'h00, 16'h0000, 16'h0000);
      send_frame(FC_WRITE, 16'h0003, 16'hBEEF, 1'b0);
      push_word(KIND_LREAD, 8'h00, 16'h0003, 16'h0000);
      send_frame(FC_READ, 16'h0000, 16'h0000, 1'b0);

      retune(8'h00);
      random_phase(28);
      retune(8'hA5);
      idle_pct = 0;
      random_phase(28);
      idle_pct = 31;
      retune($urandom);
      random_phase(28);
      retune(8'hFF);
      random_phase(28);

      req_valid = 1'b0;
      while (words_due != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
      if (fail_count == 0 && words_due == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule
